// ----- rtl/core/mie_pkg.sv -----
// shared constants and types for the modular inverse block
package mie_pkg;

	// operand and modulus width
	localparam int WIDTH = 32;
	// signed bezout coefficient width
	localparam int COEF_W = WIDTH + 2;
	// divider bit counter width
	localparam int CNT_W = $clog2(WIDTH);
	// modulus after reset
	localparam logic [WIDTH-1:0] MODULUS_RESET = WIDTH'(64'd1000000007);

	// sequencer states, one-hot
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CHECK  = 6'b000010,
		ST_DIV    = 6'b000100,
		ST_UPDATE = 6'b001000,
		ST_FIX    = 6'b010000,
		ST_RED    = 6'b100000
	} state_t;

endpackage

// ----- rtl/core/modular_inverse_ext_euclid.sv -----
// modular inverse top level: extended euclid on one shared restoring divider
// k = quotient steps, data dependent, at most about 1.5*WIDTH+2, one divider bit per cycle;
// a modulus below 2 skips the quotient steps
// one operand at a time: the next input beat is taken once the result is
// registered, while that result may still wait for the output side
// reset: arst_n low clears the sequencer and output valid at once, modulus returns to
// 1000000007
module modular_inverse_ext_euclid (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration: modulus register
	input  logic                     cfg_we,
	input  logic [mie_pkg::WIDTH-1:0] cfg_wdata,
	// input stream
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [mie_pkg::WIDTH-1:0] s_axis_tdata,   // [31:0] value
	// output stream
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [mie_pkg::WIDTH-1:0] m_axis_tdata    // [31:0] inverse
);

	localparam int W = mie_pkg::WIDTH;
	localparam int CW = mie_pkg::COEF_W;
	localparam int NW = mie_pkg::CNT_W;

	mie_pkg::state_t state_q;

	logic [W-1:0]  modulus_q;
	logic [W-1:0]  r_prev_q;
	logic [W-1:0]  r_cur_q;
	logic [CW-1:0] s_prev_q;
	logic [CW-1:0] s_cur_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvd_q;
	logic [CW-1:0] acc_q;
	logic [NW-1:0] cnt_q;
	logic          out_valid_q;
	logic [W-1:0]  out_data_q;

	logic          in_beat;
	logic          out_free;
	logic [W:0]    partial;
	logic [W:0]    diff;
	logic          qbit;
	logic [W-1:0]  rem_next;
	logic [CW-1:0] acc_next;
	logic          red_ge;
	logic [CW-1:0] red_diff;

	assign s_axis_tready = (state_q == mie_pkg::ST_IDLE);
	assign in_beat = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	// shared restoring divider step with shift-and-add quotient times coefficient
	always_comb begin
		partial = {rem_q, dvd_q[W-1]};
		diff = partial - {1'b0, r_cur_q};
		qbit = !diff[W];
		rem_next = qbit ? diff[W-1:0] : partial[W-1:0];
		acc_next = {acc_q[CW-2:0], 1'b0} + (qbit ? s_cur_q : {CW{1'b0}});
	end

	// final reduction compare against the modulus
	always_comb begin
		red_diff = s_prev_q - {{(CW-W){1'b0}}, modulus_q};
		red_ge = (s_prev_q >= {{(CW-W){1'b0}}, modulus_q});
	end

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= mie_pkg::MODULUS_RESET;
		end else if (cfg_we) begin
			modulus_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mie_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				mie_pkg::ST_IDLE: begin
					if (in_beat) begin
						state_q <= (modulus_q < W'(2)) ? mie_pkg::ST_FIX : mie_pkg::ST_CHECK;
					end
				end
				mie_pkg::ST_CHECK: begin
					state_q <= (r_cur_q == '0) ? mie_pkg::ST_FIX : mie_pkg::ST_DIV;
				end
				mie_pkg::ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= mie_pkg::ST_UPDATE;
					end
				end
				mie_pkg::ST_UPDATE: begin
					state_q <= mie_pkg::ST_CHECK;
				end
				mie_pkg::ST_FIX: begin
					state_q <= mie_pkg::ST_RED;
				end
				mie_pkg::ST_RED: begin
					if (out_free) begin
						state_q <= mie_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= mie_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// euclid datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			mie_pkg::ST_IDLE: begin
				if (in_beat) begin
					r_prev_q <= s_axis_tdata;
					r_cur_q <= modulus_q;
					s_prev_q <= (modulus_q < W'(2)) ? {CW{1'b0}} : CW'(1);
					s_cur_q <= '0;
				end
			end
			mie_pkg::ST_CHECK: begin
				rem_q <= '0;
				dvd_q <= r_prev_q;
				acc_q <= '0;
				cnt_q <= NW'(W - 1);
			end
			mie_pkg::ST_DIV: begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[W-2:0], 1'b0};
				acc_q <= acc_next;
				cnt_q <= cnt_q - NW'(1);
			end
			mie_pkg::ST_UPDATE: begin
				r_prev_q <= r_cur_q;
				r_cur_q <= rem_q;
				s_prev_q <= s_cur_q;
				s_cur_q <= s_prev_q - acc_q;
			end
			mie_pkg::ST_FIX: begin
				// negative coefficient: add the modulus once
				if (s_prev_q[CW-1]) begin
					s_prev_q <= s_prev_q + {{(CW-W){1'b0}}, modulus_q};
				end
			end
			mie_pkg::ST_RED: begin
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == mie_pkg::ST_RED && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mie_pkg::ST_RED && out_free) begin
			out_data_q <= red_ge ? red_diff[W-1:0] : s_prev_q[W-1:0];
		end
	end

	// divider partial remainder stays below the divisor
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mie_pkg::ST_DIV) |-> (rem_q < r_cur_q))
		else $error("partial remainder not below divisor");

	// divider never runs with a zero divisor
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mie_pkg::ST_DIV) |-> (r_cur_q != '0))
		else $error("divide step with zero divisor");

	// divider keeps stepping until its bit count runs out
	a_div_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mie_pkg::ST_DIV && cnt_q != '0) |=> (state_q == mie_pkg::ST_DIV))
		else $error("divide left early");

	// a new result appears only out of the reduction state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == mie_pkg::ST_RED))
		else $error("output valid without reduction");

endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench for the extended euclid modular inverse block
`timescale 1ns / 100ps

module tb;

	localparam int WIDTH = mie_pkg::WIDTH;
	localparam int LONG_HOLD = 4000;
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 138;
	localparam int DIR_ROWS = 20;

	// one directed row: optional modulus write, operand, and a typed answer where obvious
	typedef struct {
		bit             set_mod;
		logic [WIDTH-1:0] mod;
		logic [WIDTH-1:0] value;
		bit             known;
		logic [WIDTH-1:0] inverse;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [WIDTH-1:0] cfg_wdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [WIDTH-1:0] s_axis_tdata;   // [31:0] value
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [WIDTH-1:0] m_axis_tdata;   // [31:0] inverse

	logic [WIDTH-1:0] inverse_q[$];
	logic [WIDTH-1:0] modulus_now;
	int cycles = 0;
	int mismatches = 0;
	int operands_sent = 0;
	int inverses_seen = 0;
	int moduli_used = 0;
	int hold_request = 0;
	bit calm = 1'b0;

	dir_row_t dir_rows [DIR_ROWS] = '{
		// reset modulus: zero operand, one, two, m-1, operand equal to m, operand above m
		'{1'b0, 32'd0, 32'd0, 1'b1, 32'd0},
		'{1'b0, 32'd0, 32'd1, 1'b1, 32'd1},
		'{1'b0, 32'd0, 32'd2, 1'b1, 32'd500000004},
		'{1'b0, 32'd0, 32'd1000000006, 1'b1, 32'd1000000006},
		'{1'b0, 32'd0, 32'd1000000007, 1'b1, 32'd0},
		'{1'b0, 32'd0, 32'hFFFFFFFF, 1'b0, 32'd0},
		// modulus zero and modulus one give zero
		'{1'b1, 32'd0, 32'd5, 1'b1, 32'd0},
		'{1'b0, 32'd0, 32'hFFFFFFFF, 1'b1, 32'd0},
		'{1'b1, 32'd1, 32'd7, 1'b1, 32'd0},
		// smallest real modulus
		'{1'b1, 32'd2, 32'hFFFFFFFF, 1'b1, 32'd1},
		'{1'b0, 32'd0, 32'd4, 1'b1, 32'd0},
		// largest modulus, including a gcd of three
		'{1'b1, 32'hFFFFFFFF, 32'hFFFFFFFE, 1'b1, 32'hFFFFFFFE},
		'{1'b0, 32'd0, 32'd2, 1'b0, 32'd0},
		'{1'b0, 32'd0, 32'd3, 1'b0, 32'd0},
		'{1'b0, 32'd0, 32'h80000000, 1'b0, 32'd0},
		'{1'b0, 32'd0, 32'h55555555, 1'b0, 32'd0},
		// consecutive fibonacci numbers: longest quotient chain
		'{1'b1, 32'd2971215073, 32'd1836311903, 1'b0, 32'd0},
		// even modulus with gcd two, then a true inverse
		'{1'b1, 32'd12, 32'd10, 1'b0, 32'd0},
		'{1'b0, 32'd0, 32'd5, 1'b1, 32'd5},
		'{1'b1, 32'd1000000007, 32'd500000004, 1'b1, 32'd2}
	};

	modular_inverse_ext_euclid dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// clock, 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// bezout coefficient of the operand, folded into [0, m)
	function automatic logic [WIDTH-1:0] predict_inverse(input logic [WIDTH-1:0] a,
		input logic [WIDTH-1:0] m);
		bit [63:0] r_old, r_new, s_old, s_new, quo, r_nxt, s_nxt;
		if (m < 2)
			return '0;
		r_old = a;
		r_new = m;
		s_old = 64'd1;
		s_new = 64'd0;
		while (r_new != 0) begin
			quo = r_old / r_new;
			r_nxt = r_old - quo * r_new;
			s_nxt = s_old - quo * s_new;
			r_old = r_new;
			r_new = r_nxt;
			s_old = s_new;
			s_new = s_nxt;
		end
		if (s_old[63])
			s_old += m;
		return WIDTH'(s_old % m);
	endfunction

	// operand mix: zero, m and m-1, small values, multiples, reduced and full range
	function automatic logic [WIDTH-1:0] pick_operand(input logic [WIDTH-1:0] m);
		case ($urandom_range(0, 11))
			0: return '0;
			1: return m;
			2: return m - 1;
			3: return $urandom_range(1, 15);
			4: return m * $urandom_range(2, 4);
			5, 6, 7: return $urandom % m;
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [WIDTH-1:0] got,
		input logic [WIDTH-1:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at cycle %0d: %s, got %h expected %h", cycles, what, got, want);
	endtask

	// offer one operand beat and queue its expected inverse once taken
	task automatic send_operand(input logic [WIDTH-1:0] v, input bit known,
		input logic [WIDTH-1:0] typed_inverse);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		do @(posedge clk); while (!s_axis_tready);
		inverse_q.push_back(known ? typed_inverse : predict_inverse(v, modulus_now));
		operands_sent++;
	endtask

	// stop offering and wait until every queued inverse has come back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (inverse_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_modulus(input logic [WIDTH-1:0] m);
		drain_results();
		cfg_wdata <= m;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		modulus_now = m;
		moduli_used++;
	endtask

	// stimulus: reset, directed table, random phases over several moduli
	initial begin
		logic [WIDTH-1:0] m;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		modulus_now = mie_pkg::MODULUS_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_rows[r].set_mod)
				write_modulus(dir_rows[r].mod);
			send_operand(dir_rows[r].value, dir_rows[r].known, dir_rows[r].inverse);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: m = 32'd2;
				1: m = 32'hFFFFFFFF;
				2: m = $urandom_range(32'hFFFFFFFF, 2);
				3: m = $urandom_range(3, 255);
				4: m = 32'hFFFFFFFB;
				5: m = 32'h80000000;
				6: m = $urandom_range(2, 65535);
				7: m = $urandom | 32'h80000000;
				8: m = 32'd3;
				default: m = mie_pkg::MODULUS_RESET;
			endcase
			// last phase runs back to back on both sides
			if (ph == PHASES - 1)
				calm = 1'b1;
			write_modulus(m);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// output side holds off for a long stretch while beats keep coming
				if (ph == 2 && i == 30)
					hold_request <= hold_request + 1;
				// input side pauses until the block has emptied
				if (ph == 4 && i == 70)
					drain_results();
				send_operand(pick_operand(m), 1'b0, '0);
			end
		end

		drain_results();
		repeat (2000) @(posedge clk);
		while (inverse_q.size() != 0)
			report_mismatch("inverse never delivered", 'x, inverse_q.pop_front());

		$display("checked %0d inverses from %0d operands across %0d modulus settings",
			inverses_seen, operands_sent, moduli_used);
		$display("moduli zero, one, two, three, 2^31, 2^32-1 and random, with stalls on both sides");
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// output side: random stall bursts, one long hold on request
	initial begin
		int stall_left, hold_left, hold_served;
		stall_left = 0;
		hold_left = 0;
		hold_served = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != hold_served) begin
				hold_served = hold_request;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 5) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// compare each output beat with the oldest queued inverse
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			inverses_seen++;
			if (inverse_q.size() == 0)
				report_mismatch("inverse with nothing pending", m_axis_tdata, 'x);
			else if (m_axis_tdata !== inverse_q[0])
				report_mismatch("inverse", m_axis_tdata, inverse_q.pop_front());
			else
				void'(inverse_q.pop_front());
		end
	end

	// watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d inverses pending", cycles, inverse_q.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- modular_inverse_ext_euclid.f -----
rtl/core/mie_pkg.sv
rtl/core/modular_inverse_ext_euclid.sv
tb/sv/tb.sv
